// ===== rtl/evmb_pkg.sv =====
package evmb_pkg;

    // Width of the angle inputs that make up one full turn.
    localparam int ANGLE_BITS = 16;

    // Register stages of each unit, counted from the input transfer.
    localparam int SC_LAT     = 7;
    localparam int BASIS_LAT  = 3;
    localparam int XL_LAT     = 2;
    localparam int PIPE_DEPTH = SC_LAT + BASIS_LAT + XL_LAT;

    localparam logic [14:0] QUARTER_TURN = 15'd16384;
    localparam logic [31:0] SINE_K9      = 32'd172272;
    localparam logic [31:0] SINE_K [0:3] = '{32'd5026994, 32'd85569306,
                                             32'd693598669, 32'd1686629713};
    localparam logic [16:0] ONE_Q16      = 17'd65536;

    typedef logic signed [17:0] sc_t;
    typedef logic signed [18:0] elem_t;
    typedef logic signed [31:0] word_t;

    typedef struct packed {
        elem_t x;
        elem_t y;
        elem_t z;
    } vec3_t;

    typedef struct packed {
        vec3_t u;
        vec3_t v;
        vec3_t w;
    } basis_t;

    typedef struct packed {
        word_t x;
        word_t y;
        word_t z;
    } word3_t;

endpackage

// ===== rtl/evmb_sincos.sv =====
module evmb_sincos (
    input  logic          clk,
    input  logic          adv,
    input  logic [15:0]   angle,
    output evmb_pkg::sc_t sn,
    output evmb_pkg::sc_t cs
);
    import evmb_pkg::*;

    logic [14:0] xa_reg [0:5][0:1];
    logic [1:0]  q_reg  [0:5];
    logic [30:0] t2_reg [1:4][0:1];
    logic [31:0] p_reg  [1:5][0:1];
    sc_t         sn_reg;
    sc_t         cs_reg;

    logic [47:0] ph_ext;
    logic [15:0] ph;
    logic [30:0] t2_next [0:1];
    logic [31:0] p_next  [2:5][0:1];
    logic [16:0] mag     [0:1];
    sc_t         sn_next;
    sc_t         cs_next;

    // Scale the angle to a 16-bit phase.
    always_comb
    begin
        ph_ext = {32'd0, angle} & ((48'd1 << ANGLE_BITS) - 48'd1);
        ph_ext = (ph_ext << 16) >> ANGLE_BITS;
        ph     = ph_ext[15:0];
    end

    always_comb
    begin
        logic [30:0] t;
        logic [61:0] sq;
        logic [62:0] hp;
        logic [62:0] fp;
        logic [33:0] rs;
        for (int i = 0; i < 2; i++)
        begin
            t          = {xa_reg[0][i], 16'd0};
            sq         = 62'(t) * 62'(t);
            t2_next[i] = sq[60:30];
            for (int k = 2; k <= 5; k++)
            begin
                hp           = 63'(t2_reg[k-1][i]) * 63'(p_reg[k-1][i]);
                p_next[k][i] = SINE_K[k-2] - hp[61:30];
            end
            t  = {xa_reg[5][i], 16'd0};
            fp = 63'(t) * 63'(p_reg[5][i]);
            rs = 34'(fp[62:30]) + 34'd8192;
            if (rs[33:14] > 20'(ONE_Q16))
                mag[i] = ONE_Q16;
            else
                mag[i] = rs[30:14];
        end
    end

    // Unfold the quarter wave by quadrant.
    always_comb
    begin
        case (q_reg[5])
            2'd0:
            begin
                sn_next = $signed({1'b0, mag[0]});
                cs_next = $signed({1'b0, mag[1]});
            end
            2'd1:
            begin
                sn_next = $signed({1'b0, mag[1]});
                cs_next = -$signed({1'b0, mag[0]});
            end
            2'd2:
            begin
                sn_next = -$signed({1'b0, mag[0]});
                cs_next = -$signed({1'b0, mag[1]});
            end
            default:
            begin
                sn_next = -$signed({1'b0, mag[1]});
                cs_next = $signed({1'b0, mag[0]});
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_reg[0]     <= ph[15:14];
            xa_reg[0][0] <= {1'b0, ph[13:0]};
            xa_reg[0][1] <= QUARTER_TURN - {1'b0, ph[13:0]};
            for (int k = 1; k <= 5; k++)
            begin
                q_reg[k]  <= q_reg[k-1];
                xa_reg[k] <= xa_reg[k-1];
            end
            for (int i = 0; i < 2; i++)
            begin
                t2_reg[1][i] <= t2_next[i];
                p_reg[1][i]  <= SINE_K9;
                for (int k = 2; k <= 4; k++)
                    t2_reg[k][i] <= t2_reg[k-1][i];
                for (int k = 2; k <= 5; k++)
                    p_reg[k][i] <= p_next[k][i];
            end
            sn_reg <= sn_next;
            cs_reg <= cs_next;
        end
    end

    assign sn = sn_reg;
    assign cs = cs_reg;

endmodule

// ===== rtl/evmb_basis.sv =====
module evmb_basis (
    input  logic             clk,
    input  logic             adv,
    input  evmb_pkg::sc_t    s1,
    input  evmb_pkg::sc_t    c1,
    input  evmb_pkg::sc_t    s2,
    input  evmb_pkg::sc_t    c2,
    input  evmb_pkg::sc_t    s3,
    input  evmb_pkg::sc_t    c3,
    output evmb_pkg::basis_t basis
);
    import evmb_pkg::*;

    // Pair products, Q32.
    logic signed [35:0] c1c3_reg, s1s2_reg, c1s2_reg, c3s1_reg, c1s3_reg;
    logic signed [35:0] s1s3_reg, c2s3_reg, c2c3_reg, c2s1_reg, c1c2_reg;
    sc_t                s2_reg, s3_reg, c3_reg;

    // Triple sums, Q48, and pass-through pairs.
    logic signed [55:0] u0_reg, u2_reg, v0_reg, v2_reg;
    logic signed [35:0] u1_reg, v1_reg, w0_reg, w2_reg;
    elem_t              w1_reg;

    basis_t             basis_reg;
    basis_t             basis_next;

    function automatic elem_t rnd48(input logic signed [55:0] v);
        logic signed [55:0] b;
        b = v + 56'sd2147483648;
        return b[50:32];
    endfunction

    function automatic elem_t rnd32(input logic signed [35:0] v);
        logic signed [36:0] b;
        b = 37'(v) + 37'sd32768;
        return b[34:16];
    endfunction

    always_comb
    begin
        basis_next.u.x = rnd48(u0_reg);
        basis_next.u.y = rnd32(u1_reg);
        basis_next.u.z = rnd48(u2_reg);
        basis_next.v.x = rnd48(v0_reg);
        basis_next.v.y = rnd32(v1_reg);
        basis_next.v.z = rnd48(v2_reg);
        basis_next.w.x = rnd32(w0_reg);
        basis_next.w.y = w1_reg;
        basis_next.w.z = rnd32(w2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1c3_reg <= 36'(c1) * 36'(c3);
            s1s2_reg <= 36'(s1) * 36'(s2);
            c1s2_reg <= 36'(c1) * 36'(s2);
            c3s1_reg <= 36'(c3) * 36'(s1);
            c1s3_reg <= 36'(c1) * 36'(s3);
            s1s3_reg <= 36'(s1) * 36'(s3);
            c2s3_reg <= 36'(c2) * 36'(s3);
            c2c3_reg <= 36'(c2) * 36'(c3);
            c2s1_reg <= 36'(c2) * 36'(s1);
            c1c2_reg <= 36'(c1) * 36'(c2);
            s2_reg   <= s2;
            s3_reg   <= s3;
            c3_reg   <= c3;

            u0_reg <= (56'(c1c3_reg) <<< 16) + 56'(s1s2_reg) * 56'(s3_reg);
            u2_reg <= 56'(c1s2_reg) * 56'(s3_reg) - (56'(c3s1_reg) <<< 16);
            v0_reg <= 56'(s1s2_reg) * 56'(c3_reg) - (56'(c1s3_reg) <<< 16);
            v2_reg <= 56'(c1c3_reg) * 56'(s2_reg) + (56'(s1s3_reg) <<< 16);
            u1_reg <= c2s3_reg;
            v1_reg <= c2c3_reg;
            w0_reg <= c2s1_reg;
            w2_reg <= c1c2_reg;
            w1_reg <= -19'(s2_reg);

            basis_reg <= basis_next;
        end
    end

    assign basis = basis_reg;

endmodule

// ===== rtl/evmb_xlate.sv =====
module evmb_xlate (
    input  logic             clk,
    input  logic             adv,
    input  evmb_pkg::basis_t basis_in,
    input  evmb_pkg::word3_t pos,
    output evmb_pkg::basis_t basis_out,
    output evmb_pkg::word3_t xlt
);
    import evmb_pkg::*;

    logic signed [50:0] prod_reg [0:2][0:2];
    basis_t             basis_reg [0:1];
    word3_t             xlt_reg;

    elem_t              bv [0:2][0:2];
    word_t              pv [0:2];
    word_t              xlt_next [0:2];

    always_comb
    begin
        bv[0][0] = basis_in.u.x;
        bv[0][1] = basis_in.u.y;
        bv[0][2] = basis_in.u.z;
        bv[1][0] = basis_in.v.x;
        bv[1][1] = basis_in.v.y;
        bv[1][2] = basis_in.v.z;
        bv[2][0] = basis_in.w.x;
        bv[2][1] = basis_in.w.y;
        bv[2][2] = basis_in.w.z;
        pv[0]    = pos.x;
        pv[1]    = pos.y;
        pv[2]    = pos.z;
    end

    // Negate the dot product, round half up to Q16 and saturate.
    always_comb
    begin
        logic signed [53:0] dsum;
        logic signed [53:0] rnd;
        for (int r = 0; r < 3; r++)
        begin
            dsum = 54'(prod_reg[r][0]) + 54'(prod_reg[r][1]) + 54'(prod_reg[r][2]);
            rnd  = (54'sd32768 - dsum) >>> 16;
            if (rnd > 54'sd2147483647)
                xlt_next[r] = 32'sh7FFFFFFF;
            else if (rnd < -54'sd2147483648)
                xlt_next[r] = 32'sh80000000;
            else
                xlt_next[r] = rnd[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    prod_reg[r][c] <= 51'(bv[r][c]) * 51'(pv[c]);
            basis_reg[0] <= basis_in;
            basis_reg[1] <= basis_reg[0];
            xlt_reg.x    <= xlt_next[0];
            xlt_reg.y    <= xlt_next[1];
            xlt_reg.z    <= xlt_next[2];
        end
    end

    assign basis_out = basis_reg[1];
    assign xlt       = xlt_reg;

endmodule

// ===== rtl/evmb_colseq.sv =====
module evmb_colseq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  evmb_pkg::basis_t basis,
    input  evmb_pkg::word3_t xlt,
    input  evmb_pkg::word3_t pos,
    output logic             take,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             matrix_select,
    output logic [1:0]       column_index,
    output logic signed [31:0] elem_row0,
    output logic signed [31:0] elem_row1,
    output logic signed [31:0] elem_row2,
    output logic signed [31:0] elem_row3,
    output logic             last_column
);
    import evmb_pkg::*;

    localparam logic [2:0] SQ_VIEW0 = 3'd0;
    localparam logic [2:0] SQ_VIEW1 = 3'd1;
    localparam logic [2:0] SQ_VIEW2 = 3'd2;
    localparam logic [2:0] SQ_VIEW3 = 3'd3;
    localparam logic [2:0] SQ_INV0  = 3'd4;
    localparam logic [2:0] SQ_INV1  = 3'd5;
    localparam logic [2:0] SQ_INV2  = 3'd6;
    localparam logic [2:0] SQ_INV3  = 3'd7;

    logic       busy_reg, busy_next;
    logic [2:0] cnt_reg, cnt_next;
    basis_t     basis_reg;
    word3_t     xlt_reg;
    word3_t     pos_reg;
    logic       fire;
    logic       done;

    function automatic word_t ext(input elem_t e);
        return 32'(e);
    endfunction

    assign fire = busy_reg && !out_stall;
    assign done = fire && (cnt_reg == SQ_INV3);
    assign take = !busy_reg || done;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (load)
        begin
            busy_next = 1'b1;
            cnt_next  = SQ_VIEW0;
        end
        else if (fire)
        begin
            busy_next = !done;
            cnt_next  = cnt_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= SQ_VIEW0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            basis_reg <= basis;
            xlt_reg   <= xlt;
            pos_reg   <= pos;
        end
    end

    assign out_valid     = busy_reg;
    assign matrix_select = cnt_reg[2];
    assign column_index  = cnt_reg[1:0];
    assign last_column   = (cnt_reg == SQ_INV3);

    always_comb
    begin
        elem_row3 = 32'sd0;
        case (cnt_reg)
            SQ_VIEW0:
            begin
                elem_row0 = ext(basis_reg.u.x);
                elem_row1 = ext(basis_reg.v.x);
                elem_row2 = ext(basis_reg.w.x);
            end
            SQ_VIEW1:
            begin
                elem_row0 = ext(basis_reg.u.y);
                elem_row1 = ext(basis_reg.v.y);
                elem_row2 = ext(basis_reg.w.y);
            end
            SQ_VIEW2:
            begin
                elem_row0 = ext(basis_reg.u.z);
                elem_row1 = ext(basis_reg.v.z);
                elem_row2 = ext(basis_reg.w.z);
            end
            SQ_VIEW3:
            begin
                elem_row0 = xlt_reg.x;
                elem_row1 = xlt_reg.y;
                elem_row2 = xlt_reg.z;
                elem_row3 = 32'(ONE_Q16);
            end
            SQ_INV0:
            begin
                elem_row0 = ext(basis_reg.u.x);
                elem_row1 = ext(basis_reg.u.y);
                elem_row2 = ext(basis_reg.u.z);
            end
            SQ_INV1:
            begin
                elem_row0 = ext(basis_reg.v.x);
                elem_row1 = ext(basis_reg.v.y);
                elem_row2 = ext(basis_reg.v.z);
            end
            SQ_INV2:
            begin
                elem_row0 = ext(basis_reg.w.x);
                elem_row1 = ext(basis_reg.w.y);
                elem_row2 = ext(basis_reg.w.z);
            end
            default:
            begin
                elem_row0 = pos_reg.x;
                elem_row1 = pos_reg.y;
                elem_row2 = pos_reg.z;
                elem_row3 = 32'(ONE_Q16);
            end
        endcase
    end

endmodule

// ===== rtl/euler_view_matrix_builder_core.sv =====
// Euler (yaw Y, pitch X, roll Z) view matrix builder, Q16.16 fixed point.
// Input channel: in_valid / in_stall carry one camera position (pos_x..z)
// and three 16-bit binary angles per transfer. Output channel: out_valid /
// out_stall carry one matrix column per transfer, eight per input item:
// view columns 0..3, then inverse view columns 0..3 (last_column marks the
// final one). matrix_select and column_index name the column.
// Pipeline: 7 stages of sine/cosine polynomial, 3 of basis products and 2
// of translation dot products feed the column sequencer, which sends one
// column per output transfer, one per cycle while out_stall is low, and
// takes a new item only when idle or as its last column goes out. The
// 12-stage pipeline itself takes an item every cycle unless in_stall is
// high and holds up to 12 items in flight plus one being sent, so successive
// items stream without gaps on the output.
// Stall: when the last stage holds an item that the busy sequencer cannot
// take, the whole pipeline freezes and in_stall rises; nothing is dropped.
// Reset: rst_n (async, active low) clears all valid bits and the sequencer;
// items in flight are discarded. There is no configuration.
module euler_view_matrix_builder_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [15:0]        angle_x,
    input  logic [15:0]        angle_y,
    input  logic [15:0]        angle_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               matrix_select,
    output logic [1:0]         column_index,
    output logic signed [31:0] elem_row0,
    output logic signed [31:0] elem_row1,
    output logic signed [31:0] elem_row2,
    output logic signed [31:0] elem_row3,
    output logic               last_column
);
    import evmb_pkg::*;

    logic   vld_reg [0:PIPE_DEPTH-1];
    word3_t pos_reg [0:PIPE_DEPTH-1];
    word3_t pos_in;
    logic   adv;
    logic   take;
    logic   load;

    sc_t    sx, cx, sy, cy, sz, cz;
    basis_t basis_b;
    basis_t basis_x;
    word3_t xlt;

    // Advance the pipeline whenever its last stage is empty or drains.
    assign adv      = !vld_reg[PIPE_DEPTH-1] || take;
    assign load     = vld_reg[PIPE_DEPTH-1] && take;
    assign in_stall = !adv;

    assign pos_in.x = pos_x;
    assign pos_in.y = pos_y;
    assign pos_in.z = pos_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_DEPTH; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < PIPE_DEPTH; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    // Carry the position alongside the item.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pos_reg[0] <= pos_in;
            for (int i = 1; i < PIPE_DEPTH; i++)
                pos_reg[i] <= pos_reg[i-1];
        end
    end

    evmb_sincos u_sc_x (.clk(clk), .adv(adv), .angle(angle_x), .sn(sx), .cs(cx));
    evmb_sincos u_sc_y (.clk(clk), .adv(adv), .angle(angle_y), .sn(sy), .cs(cy));
    evmb_sincos u_sc_z (.clk(clk), .adv(adv), .angle(angle_z), .sn(sz), .cs(cz));

    // Index 1 is yaw, 2 is pitch, 3 is roll.
    evmb_basis u_basis (
        .clk   (clk),
        .adv   (adv),
        .s1    (sy),
        .c1    (cy),
        .s2    (sx),
        .c2    (cx),
        .s3    (sz),
        .c3    (cz),
        .basis (basis_b)
    );

    evmb_xlate u_xlate (
        .clk       (clk),
        .adv       (adv),
        .basis_in  (basis_b),
        .pos       (pos_reg[SC_LAT+BASIS_LAT-1]),
        .basis_out (basis_x),
        .xlt       (xlt)
    );

    evmb_colseq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .basis         (basis_x),
        .xlt           (xlt),
        .pos           (pos_reg[PIPE_DEPTH-1]),
        .take          (take),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .matrix_select (matrix_select),
        .column_index  (column_index),
        .elem_row0     (elem_row0),
        .elem_row1     (elem_row1),
        .elem_row2     (elem_row2),
        .elem_row3     (elem_row3),
        .last_column   (last_column)
    );

endmodule

// ===== rtl/evmb_checker.sv =====
module evmb_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic               matrix_select,
    input logic [1:0]         column_index,
    input logic signed [31:0] elem_row3,
    input logic               last_column
);

    // A stalled column holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(column_index)
            && $stable(matrix_select))
        else $error("stalled column changed");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_column |-> column_index == 2'd3 && matrix_select)
        else $error("last flag on wrong column");

    // Columns of one item follow back to back in order.
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_column |=>
            out_valid && column_index == 2'($past(column_index) + 2'd1))
        else $error("column order broken");

    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && column_index == 2'd3 |-> elem_row3 == 32'sd65536)
        else $error("bottom row of translation column not one");

    // Input backpressure only while columns are being sent.
    a_push: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no column pending");

endmodule

bind euler_view_matrix_builder_core evmb_checker u_evmb_checker (.*);

// ===== dv/tb_euler_view_matrix_builder_core.sv =====
`timescale 1ns / 100ps

module tb_euler_view_matrix_builder_core;
    import evmb_pkg::*;

    // One camera setup: position plus the three binary angles.
    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [15:0]        ax;
        logic [15:0]        ay;
        logic [15:0]        az;
    } camera_t;

    // One matrix column as it leaves the block.
    typedef struct {
        logic        sel;
        logic [1:0]  col;
        logic [31:0] r0;
        logic [31:0] r1;
        logic [31:0] r2;
        logic [31:0] r3;
        logic        last;
    } column_t;

    localparam int ANGLE_UP = (ANGLE_BITS > 16) ? ANGLE_BITS - 16 : 0;
    localparam int ANGLE_DN = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
    localparam longint ONE  = 65536;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [31:0] pos_x = '0;
    logic signed [31:0] pos_y = '0;
    logic signed [31:0] pos_z = '0;
    logic [15:0]        angle_x = '0;
    logic [15:0]        angle_y = '0;
    logic [15:0]        angle_z = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               matrix_select;
    logic [1:0]         column_index;
    logic signed [31:0] elem_row0;
    logic signed [31:0] elem_row1;
    logic signed [31:0] elem_row2;
    logic signed [31:0] elem_row3;
    logic               last_column;

    camera_t camera_queue[$];     // setups not yet offered to the block
    column_t column_queue[$];     // columns predicted, not yet seen
    camera_t offered;
    column_t want;
    int      cameras_sent = 0;
    int      error_count  = 0;
    int      send_idle_pct = 28;
    int      recv_idle_pct = 52;
    int      hold_cycles = 0;
    bit      hold_done = 1'b0;

    euler_view_matrix_builder_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .angle_x       (angle_x),
        .angle_y       (angle_y),
        .angle_z       (angle_z),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .matrix_select (matrix_select),
        .column_index  (column_index),
        .elem_row0     (elem_row0),
        .elem_row1     (elem_row1),
        .elem_row2     (elem_row2),
        .elem_row3     (elem_row3),
        .last_column   (last_column)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Round half up: floor((v + 2^(n-1)) / 2^n).
    function automatic longint round_q(longint v, int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clamp_word(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Sine over a quarter turn: x in 0..16384, Q16 result in 0..65536.
    // Odd 9th-order polynomial in Q30, Horner form, every product truncated.
    function automatic longint quarter_wave(longint x);
        longint t;
        longint t2;
        longint acc;
        t   = x <<< 16;
        t2  = (t * t) >>> 30;
        acc = longint'(SINE_K9);
        for (int i = 0; i < 4; i++)
            acc = longint'(SINE_K[i]) - ((t2 * acc) >>> 30);
        acc = (t * acc) >>> 30;
        acc = (acc + 8192) >>> 14;
        if (acc < 0)
            acc = 0;
        if (acc > ONE)
            acc = ONE;
        return acc;
    endfunction

    task automatic angle_sincos(input logic [15:0] angle, output longint sn,
                                output longint cs);
        longint a;
        longint ph;
        longint sa;
        longint sb;
        a  = longint'(angle) & ((longint'(1) <<< ANGLE_BITS) - 1);
        ph = ((a >> ANGLE_UP) << ANGLE_DN) & 64'hFFFF;
        sa = quarter_wave(ph & 64'h3FFF);
        sb = quarter_wave(16384 - (ph & 64'h3FFF));
        case (ph >> 14)
            0: begin sn = sa;  cs = sb;  end
            1: begin sn = sb;  cs = -sa; end
            2: begin sn = -sa; cs = -sb; end
            default: begin sn = -sb; cs = sa; end
        endcase
    endtask

    function automatic longint view_offset(longint bx, longint by, longint bz,
                                           longint px, longint py, longint pz);
        return clamp_word(round_q(-(bx * px + by * py + bz * pz), 16));
    endfunction

    task automatic push_column(bit sel, int col, longint r0, longint r1,
                               longint r2, longint r3, bit last);
        column_t c;
        c.sel  = sel;
        c.col  = col[1:0];
        c.r0   = r0[31:0];
        c.r1   = r1[31:0];
        c.r2   = r2[31:0];
        c.r3   = r3[31:0];
        c.last = last;
        column_queue.push_back(c);
    endtask

    // Expected eight columns: view matrix, then its inverse.
    task automatic build_view_columns(camera_t cam);
        longint s1, c1, s2, c2, s3, c3;
        longint px, py, pz;
        longint ux, uy, uz, vx, vy, vz, wx, wy, wz;
        px = cam.px;
        py = cam.py;
        pz = cam.pz;
        angle_sincos(cam.ax, s2, c2);   // pitch
        angle_sincos(cam.ay, s1, c1);   // yaw
        angle_sincos(cam.az, s3, c3);   // roll
        ux = round_q(c1 * c3 * ONE + s1 * s2 * s3, 32);
        uy = round_q(c2 * s3, 16);
        uz = round_q(c1 * s2 * s3 - c3 * s1 * ONE, 32);
        vx = round_q(c3 * s1 * s2 - c1 * s3 * ONE, 32);
        vy = round_q(c2 * c3, 16);
        vz = round_q(c1 * c3 * s2 + s1 * s3 * ONE, 32);
        wx = round_q(c2 * s1, 16);
        wy = -s2;
        wz = round_q(c1 * c2, 16);
        push_column(0, 0, ux, vx, wx, 0, 0);
        push_column(0, 1, uy, vy, wy, 0, 0);
        push_column(0, 2, uz, vz, wz, 0, 0);
        push_column(0, 3, view_offset(ux, uy, uz, px, py, pz),
                    view_offset(vx, vy, vz, px, py, pz),
                    view_offset(wx, wy, wz, px, py, pz), ONE, 0);
        push_column(1, 0, ux, uy, uz, 0, 0);
        push_column(1, 1, vx, vy, vz, 0, 0);
        push_column(1, 2, wx, wy, wz, 0, 0);
        push_column(1, 3, px, py, pz, ONE, 1);
    endtask

    task automatic add_camera(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                              logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
        camera_t c;
        c.px = px;
        c.py = py;
        c.pz = pz;
        c.ax = ax;
        c.ay = ay;
        c.az = az;
        camera_queue.push_back(c);
    endtask

    function automatic logic [31:0] rand_pos();
        // One draw in three is a small scene coordinate, the rest anywhere in the range.
        if ($urandom_range(2) == 0)
            return $urandom_range(2 * 1000 * 65536) - 1000 * 65536;
        return $urandom;
    endfunction

    // Driver: offer the next setup, hold it while stalled, idle at random.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else begin
            if (in_valid && !in_stall) begin
                build_view_columns(offered);
                cameras_sent++;
            end
            if (in_valid && in_stall) begin
                // hold the stalled transfer as it is
            end
            else if (camera_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                offered = camera_queue.pop_front();
                pos_x   <= offered.px;
                pos_y   <= offered.py;
                pos_z   <= offered.pz;
                angle_x <= offered.ax;
                angle_y <= offered.ay;
                angle_z <= offered.az;
                in_valid <= 1'b1;
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: random, swapped halfway, then one long hold-off so the
    // pipeline fills and pushes back on the input.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end
        else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_stall   <= 1'b1;
        end
        else if (!hold_done && cameras_sent >= 185) begin
            hold_done   <= 1'b1;
            hold_cycles <= 400;
            out_stall   <= 1'b1;
        end
        else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Idle mix by progress: sender light / receiver heavy, then swapped, then none.
    always @(posedge clk) begin
        if (cameras_sent >= 180) begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
        end
        else if (cameras_sent >= 90) begin
            send_idle_pct <= 52;
            recv_idle_pct <= 28;
        end
    end

    // Monitor: compare each column transfer with the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (column_queue.size() == 0) begin
                $error("unexpected column: select %0d column %0d", matrix_select,
                       column_index);
                error_count++;
            end
            else begin
                want = column_queue.pop_front();
                if (matrix_select !== want.sel) begin
                    $error("matrix_select: expected %0d, got %0d", want.sel, matrix_select);
                    error_count++;
                end
                if (column_index !== want.col) begin
                    $error("column_index: expected %0d, got %0d", want.col, column_index);
                    error_count++;
                end
                if (elem_row0 !== want.r0) begin
                    $error("elem_row0: expected %h, got %h", want.r0, elem_row0);
                    error_count++;
                end
                if (elem_row1 !== want.r1) begin
                    $error("elem_row1: expected %h, got %h", want.r1, elem_row1);
                    error_count++;
                end
                if (elem_row2 !== want.r2) begin
                    $error("elem_row2: expected %h, got %h", want.r2, elem_row2);
                    error_count++;
                end
                if (elem_row3 !== want.r3) begin
                    $error("elem_row3: expected %h, got %h", want.r3, elem_row3);
                    error_count++;
                end
                if (last_column !== want.last) begin
                    $error("last_column: expected %0d, got %0d", want.last, last_column);
                    error_count++;
                end
            end
        end
    end

    initial begin
        // Directed: identity, quadrant edges, 45 degrees, full-scale positions
        // that saturate the translation, and the top angle code.
        add_camera(0, 0, 0, 0, 0, 0);
        add_camera(32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 0, 0, 0);
        add_camera(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0);
        add_camera(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
        add_camera(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8192, 8192, 8192);
        add_camera(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8192, 8192, 8192);
        add_camera(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 57344, 24576, 40960);
        add_camera(32'h0003_8000, 32'hFFFF_FFFF, 32'h0000_0001, 16384, 0, 0);
        add_camera(32'h0003_8000, 32'hFFFF_FFFF, 32'h0000_0001, 0, 16384, 0);
        add_camera(32'h0003_8000, 32'hFFFF_FFFF, 32'h0000_0001, 0, 0, 16384);
        add_camera(32'h0010_0000, 32'h0020_0000, 32'h0030_0000, 32768, 32768, 32768);
        add_camera(32'h0010_0000, 32'h0020_0000, 32'h0030_0000, 49152, 49152, 49152);
        add_camera(32'hFFF0_0000, 32'h0020_0000, 32'hFFD0_0000, 65535, 65535, 65535);
        add_camera(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 1, 1, 1);
        add_camera(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16383, 32767, 49151);
        add_camera(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16385, 32769, 49153);
        add_camera(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 16'hAAAA, 16'h5555, 16'hFFFF);
        for (int i = 0; i < 200; i++)
            add_camera(rand_pos(), rand_pos(), rand_pos(), $urandom, $urandom, $urandom);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: all setups accepted, every column back, then latency margin.
        while (camera_queue.size() > 0 || in_valid || column_queue.size() > 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 16) @(posedge clk);

        if (error_count == 0 && column_queue.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
